// File: rtl/touch_auto_repeat_clock_control_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the touch auto-repeat clock controller
// Immediate-implication and next-cycle checks, clocked on i_clk and held
// off while i_rst_n is low. Empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef TOUCH_AUTO_REPEAT_CLOCK_CONTROL_DEFINES_SVH
`define TOUCH_AUTO_REPEAT_CLOCK_CONTROL_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TARC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("tarc assertion failed");
// next-cycle implication
`define TARC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("tarc assertion failed");
`else
`define TARC_ASSERT_IMP(lbl, ante, cons)
`define TARC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/tarc_pkg.sv
// ----------------------------------------------------------------------------
// tarc_pkg
// Types and constants shared by the touch auto-repeat clock controller.
// ----------------------------------------------------------------------------
package tarc_pkg;

    typedef enum logic [2:0] {
        ST_INIT      = 3'd0,
        ST_UNTOUCHED = 3'd1,
        ST_WAIT      = 3'd2,
        ST_SETTLE    = 3'd3,
        ST_HOLD      = 3'd4,
        ST_RATE      = 3'd5,
        ST_EXPIRED   = 3'd6,
        ST_RUN       = 3'd7
    } t_state;

    // pulses produced by one tick
    typedef struct packed {
        logic inc_dec;
        logic advance_second;
        logic clear_touch;
    } t_pulses;

    localparam int unsigned LIMIT_W = 8;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    // register word indexes (paddr[3:2])
    localparam logic [1:0] REG_SECOND_LIMIT = 2'd0;
    localparam logic [1:0] REG_SETTLE_TICKS = 2'd1;
    localparam logic [1:0] REG_HOLD_DELAY   = 2'd2;
    localparam logic [1:0] REG_REPEAT_TICKS = 2'd3;

    localparam logic [LIMIT_W-1:0] RST_SECOND_LIMIT = 8'd20;
    localparam logic [LIMIT_W-1:0] RST_SETTLE_TICKS = 8'd1;
    localparam logic [LIMIT_W-1:0] RST_HOLD_DELAY   = 8'd10;
    localparam logic [LIMIT_W-1:0] RST_REPEAT_TICKS = 8'd1;

endpackage

// File: rtl/tarc_step.sv
// ----------------------------------------------------------------------------
// tarc_step
// Next state, tick counters and pulses for one timer tick.
// ----------------------------------------------------------------------------
module tarc_step
    import tarc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 8
) (
    input  t_state                   i_state,
    input  logic                     i_touched,
    input  logic [COUNT_WIDTH-1:0]   i_second_count,
    input  logic [COUNT_WIDTH-1:0]   i_settle_count,
    input  logic [COUNT_WIDTH-1:0]   i_hold_count,
    input  logic [COUNT_WIDTH-1:0]   i_repeat_count,
    input  logic [LIMIT_W-1:0]       i_second_limit,
    input  logic [LIMIT_W-1:0]       i_settle_ticks,
    input  logic [LIMIT_W-1:0]       i_hold_delay_ticks,
    input  logic [LIMIT_W-1:0]       i_repeat_ticks,
    output t_state                   o_state,
    output logic [COUNT_WIDTH-1:0]   o_second_count,
    output logic [COUNT_WIDTH-1:0]   o_settle_count,
    output logic [COUNT_WIDTH-1:0]   o_hold_count,
    output logic [COUNT_WIDTH-1:0]   o_repeat_count,
    output t_pulses                  o_pulses
);

    // compare width covers both the counter and the 8-bit limit registers
    localparam int unsigned CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_ONE;
    endfunction

    logic [COUNT_WIDTH-1:0] settle_inc, hold_inc, repeat_inc, second_inc;
    logic                   settle_hit, hold_hit, repeat_hit, second_over;

    assign settle_inc = sat_inc(i_settle_count);
    assign hold_inc   = sat_inc(i_hold_count);
    assign repeat_inc = sat_inc(i_repeat_count);
    assign second_inc = sat_inc(i_second_count);

    assign settle_hit  = CMP_W'(settle_inc) == CMP_W'(i_settle_ticks);
    assign hold_hit    = CMP_W'(hold_inc)   == CMP_W'(i_hold_delay_ticks);
    assign repeat_hit  = CMP_W'(repeat_inc) == CMP_W'(i_repeat_ticks);
    assign second_over = CMP_W'(i_second_count) > CMP_W'(i_second_limit);

    // next state
    always_comb begin
        o_state = i_state;
        case (i_state)
            ST_INIT:      o_state = ST_UNTOUCHED;
            ST_UNTOUCHED: if (i_touched) o_state = ST_SETTLE;
            ST_WAIT:      o_state = i_touched ? ST_SETTLE : ST_RUN;
            ST_SETTLE:    if (settle_hit) o_state = i_touched ? ST_HOLD : ST_WAIT;
            ST_HOLD: begin
                if (!i_touched) o_state = ST_WAIT;
                else if (hold_hit) o_state = ST_RATE;
            end
            ST_RATE: begin
                if (!i_touched) o_state = ST_WAIT;
                else if (repeat_hit) o_state = ST_EXPIRED;
            end
            ST_EXPIRED:   o_state = i_touched ? ST_RATE : ST_WAIT;
            ST_RUN:       if (i_touched) o_state = ST_SETTLE;
            default:      o_state = ST_INIT;
        endcase
    end

    // counters and pulses
    always_comb begin
        o_second_count = i_second_count;
        o_settle_count = i_settle_count;
        o_hold_count   = i_hold_count;
        o_repeat_count = i_repeat_count;
        o_pulses       = '0;
        case (i_state)
            ST_UNTOUCHED: begin
                o_second_count       = second_inc;
                o_pulses.clear_touch = i_touched;
            end
            ST_WAIT: begin
                o_settle_count = '0;
                o_hold_count   = '0;
                o_repeat_count = '0;
                if (!i_touched) o_second_count = second_inc;
                o_pulses.clear_touch = i_touched;
            end
            ST_SETTLE: begin
                o_settle_count   = settle_inc;
                o_pulses.inc_dec = settle_hit && !i_touched;
            end
            ST_HOLD: begin
                o_hold_count     = hold_inc;
                o_pulses.inc_dec = !i_touched || hold_hit;
            end
            ST_RATE:    o_repeat_count = repeat_inc;
            ST_EXPIRED: begin
                o_repeat_count   = '0;
                o_pulses.inc_dec = i_touched;
            end
            ST_RUN: begin
                // drop the count on a second pulse, then count this tick unless touched
                o_pulses.advance_second = second_over;
                if (i_touched) begin
                    o_second_count       = second_over ? '0 : i_second_count;
                    o_pulses.clear_touch = 1'b1;
                end else begin
                    o_second_count = second_over ? CNT_ONE : second_inc;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/touch_auto_repeat_clock_control.sv
// ----------------------------------------------------------------------------
// touch_auto_repeat_clock_control
// Typematic auto-repeat controller for a touch-set clock: one timer tick in,
// one set of pulses plus the controller state out.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ---------------------------
//  tick      in         i_in_valid / o_in_stall   i_touched
//  result    out        o_out_valid / i_out_stall o_inc_dec_pulse,
//                                                 o_advance_second_pulse,
//                                                 o_clear_touch_pulse,
//                                                 o_control_state
//  config    in         APB psel/penable/pready   paddr, pwdata, prdata
//
//  One tick request per clock while o_in_stall is low; its result appears in
//  the output register on the next cycle.
//  The rate is set by the single output register: a tick is taken whenever
//  that register is empty or is being drained in the same cycle.
//  Synchronous active-low reset returns the controller to init, clears all
//  tick counters and loads the timing registers with their defaults.
//  A stall on the result side holds the result and stalls the tick side.
//
`include "touch_auto_repeat_clock_control_defines.svh"

module touch_auto_repeat_clock_control
    import tarc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // tick requests
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_touched,
    // results
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_inc_dec_pulse,
    output logic              o_advance_second_pulse,
    output logic              o_clear_touch_pulse,
    output logic [2:0]        o_control_state,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // ------------------------------------------------------------------
    // Timing registers
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0] r_second_limit, r_settle_ticks, r_hold_delay, r_repeat_ticks;
    logic               cfg_write;
    logic [1:0]         cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second_limit <= RST_SECOND_LIMIT;
            r_settle_ticks <= RST_SETTLE_TICKS;
            r_hold_delay   <= RST_HOLD_DELAY;
            r_repeat_ticks <= RST_REPEAT_TICKS;
        end else if (cfg_write) begin
            // keep the low byte only
            case (cfg_index)
                REG_SECOND_LIMIT: r_second_limit <= pwdata[LIMIT_W-1:0];
                REG_SETTLE_TICKS: r_settle_ticks <= pwdata[LIMIT_W-1:0];
                REG_HOLD_DELAY:   r_hold_delay   <= pwdata[LIMIT_W-1:0];
                REG_REPEAT_TICKS: r_repeat_ticks <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_index)
            REG_SECOND_LIMIT: prdata = DATA_W'(r_second_limit);
            REG_SETTLE_TICKS: prdata = DATA_W'(r_settle_ticks);
            REG_HOLD_DELAY:   prdata = DATA_W'(r_hold_delay);
            REG_REPEAT_TICKS: prdata = DATA_W'(r_repeat_ticks);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Controller state and tick counters
    // ------------------------------------------------------------------
    t_state                 r_state, n_state;
    logic [COUNT_WIDTH-1:0] r_second_count, n_second_count;
    logic [COUNT_WIDTH-1:0] r_settle_count, n_settle_count;
    logic [COUNT_WIDTH-1:0] r_hold_count,   n_hold_count;
    logic [COUNT_WIDTH-1:0] r_repeat_count, n_repeat_count;
    t_pulses                r_pulses, n_pulses;
    logic                   r_out_valid;
    logic                   in_accept;

    // stall ticks only while a result waits and the far side is stalled
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    tarc_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_state            (r_state),
        .i_touched          (i_touched),
        .i_second_count     (r_second_count),
        .i_settle_count     (r_settle_count),
        .i_hold_count       (r_hold_count),
        .i_repeat_count     (r_repeat_count),
        .i_second_limit     (r_second_limit),
        .i_settle_ticks     (r_settle_ticks),
        .i_hold_delay_ticks (r_hold_delay),
        .i_repeat_ticks     (r_repeat_ticks),
        .o_state            (n_state),
        .o_second_count     (n_second_count),
        .o_settle_count     (n_settle_count),
        .o_hold_count       (n_hold_count),
        .o_repeat_count     (n_repeat_count),
        .o_pulses           (n_pulses)
    );

    // advance state and load the result on every accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_INIT;
            r_second_count <= '0;
            r_settle_count <= '0;
            r_hold_count   <= '0;
            r_repeat_count <= '0;
            r_pulses       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state        <= n_state;
                r_second_count <= n_second_count;
                r_settle_count <= n_settle_count;
                r_hold_count   <= n_hold_count;
                r_repeat_count <= n_repeat_count;
                r_pulses       <= n_pulses;
                r_out_valid    <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    // the state register only moves when the result slot is refilled,
    // so it always matches the result on display
    assign o_out_valid            = r_out_valid;
    assign o_inc_dec_pulse        = r_pulses.inc_dec;
    assign o_advance_second_pulse = r_pulses.advance_second;
    assign o_clear_touch_pulse    = r_pulses.clear_touch;
    assign o_control_state        = r_state;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a second pulse comes from run; a touch in the same tick moves to settle
    `TARC_ASSERT_IMP(a_adv_in_run, r_out_valid && r_pulses.advance_second,
                     r_state == ST_RUN || r_state == ST_SETTLE)
    `TARC_ASSERT_IMP(a_clr_to_settle, r_out_valid && r_pulses.clear_touch, r_state == ST_SETTLE)
    `TARC_ASSERT_IMP(a_inc_state, r_out_valid && r_pulses.inc_dec,
                     r_state == ST_WAIT || r_state == ST_RATE)
    `TARC_ASSERT_NXT(a_accept_fills, in_accept, r_out_valid)
    `TARC_ASSERT_IMP(a_stall_needs_result, o_in_stall, r_out_valid)

endmodule
